/* hdl/chled_pkg.sv */
`timescale 1ns / 1ps
// Package for the compass heading to LED block: constants, state codes,
// the arctangent table and the CORDIC result type. Depends on nothing.
package chled_pkg;

	localparam int LED_COUNT_DEF    = 7;
	localparam int CORDIC_STEPS_DEF = 16;

	// configuration register indexes
	localparam logic [7:0] REG_DECLINATION = 8'd0;
	localparam logic [7:0] REG_OFFSET      = 8'd1;

	// operation codes
	localparam logic [1:0] OP_CAL_BEGIN  = 2'd0;
	localparam logic [1:0] OP_CAL_SAMPLE = 2'd1;
	localparam logic [1:0] OP_HEADING    = 2'd2;

	localparam int ANG_W  = 26;  // degrees, 16 fraction bits
	localparam int CROSS_W = 34; // cross product components
	localparam int MUL_W  = 25;  // shared multiplier operand width

	localparam logic signed [ANG_W-1:0] ANG_90  = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] ANG_180 = 26'sd11796480;

	// calibration reset values
	localparam logic signed [15:0] MIN_RST_X = -16'sd578;
	localparam logic signed [15:0] MIN_RST_Y = -16'sd586;
	localparam logic signed [15:0] MIN_RST_Z = -16'sd425;
	localparam logic signed [15:0] MAX_RST_X = 16'sd613;
	localparam logic signed [15:0] MAX_RST_Y = 16'sd608;
	localparam logic signed [15:0] MAX_RST_Z = 16'sd542;

	localparam logic [7:0] DECL_RST   = 8'd6;
	localparam logic [7:0] OFFSET_RST = 8'd20;

	// ceil(2^28/20) and ceil(2^24/180) reciprocals
	localparam int RECIP_20  = 13421773;
	localparam int RECIP_180 = 93207;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_CORDIC,
		ST_RAW,
		ST_FILT,
		ST_FMUL,
		ST_FDIV,
		ST_VIEW,
		ST_LMUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                    done;
		logic signed [ANG_W-1:0] angle;
	} cordic_res_t;

	// atan(2^-i) in degrees with 16 fraction bits
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] i);
		logic signed [ANG_W-1:0] r;
		begin
			unique case (i)
				5'd0:  r = 26'sd2949120;
				5'd1:  r = 26'sd1740967;
				5'd2:  r = 26'sd919879;
				5'd3:  r = 26'sd466945;
				5'd4:  r = 26'sd234379;
				5'd5:  r = 26'sd117304;
				5'd6:  r = 26'sd58666;
				5'd7:  r = 26'sd29335;
				5'd8:  r = 26'sd14668;
				5'd9:  r = 26'sd7334;
				5'd10: r = 26'sd3667;
				5'd11: r = 26'sd1833;
				5'd12: r = 26'sd917;
				5'd13: r = 26'sd458;
				5'd14: r = 26'sd229;
				5'd15: r = 26'sd115;
				5'd16: r = 26'sd57;
				5'd17: r = 26'sd29;
				5'd18: r = 26'sd14;
				5'd19: r = 26'sd7;
				5'd20: r = 26'sd4;
				5'd21: r = 26'sd2;
				5'd22: r = 26'sd1;
				default: r = 26'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

/* hdl/chled_cordic.sv */
`timescale 1ns / 1ps
// Vectoring CORDIC, one micro-rotation per cycle: atan2(ey, ez) in degrees.
// Depends on chled_pkg.
module chled_cordic #(
	parameter int CORDIC_STEPS = chled_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [chled_pkg::CROSS_W-1:0]  ey,
	input  logic signed [chled_pkg::CROSS_W-1:0]  ez,
	output chled_pkg::cordic_res_t                res
);
	localparam int W = chled_pkg::CROSS_W + 24;
	localparam int AW = chled_pkg::ANG_W;
	localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

	logic signed [W-1:0]  x_q, y_q;
	logic signed [AW-1:0] z_q;
	logic [4:0]           iter_q;
	logic                 busy_q, done_q, zero_q;

	logic signed [W-1:0]  xs, ys, dx, dy;

	// scale by 2^20 into the working width
	assign xs = {{(W-chled_pkg::CROSS_W-20){ez[chled_pkg::CROSS_W-1]}}, ez, 20'b0};
	assign ys = {{(W-chled_pkg::CROSS_W-20){ey[chled_pkg::CROSS_W-1]}}, ey, 20'b0};
	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;

	// control: run for the configured number of steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				if (iter_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				iter_q <= iter_q + 5'd1;
			end
		end
	end

	// datapath: pre-rotate left half plane, then micro-rotate
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (ey == '0) && (ez == '0);
			if (ez < 0) begin
				if (ey >= 0) begin
					x_q <= ys;
					y_q <= -xs;
					z_q <= chled_pkg::ANG_90;
				end else begin
					x_q <= -ys;
					y_q <= xs;
					z_q <= -chled_pkg::ANG_90;
				end
			end else begin
				x_q <= xs;
				y_q <= ys;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + chled_pkg::atan_q16(iter_q);
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - chled_pkg::atan_q16(iter_q);
			end
		end
	end

	assign res.done  = done_q;
	assign res.angle = zero_q ? '0 : z_q;

endmodule

/* hdl/compass_heading_to_led_top.sv */
`timescale 1ns / 1ps
// Compass heading to LED pointer, top level. Uses chled_pkg, chled_cordic.
// Heading beat: cross product on the shared multiplier, then the CORDIC at one
// rotation per cycle, then the filter, the bearing error and the LED scaling.
// Calibration and unused beats go straight to the output state. One beat at a
// time; the next beat is taken in the idle state after the result loads.
// Reset restores calibration bounds, zeroes the filter and loads register
// defaults (declination 6, offset 20); no clearing pass.
module compass_heading_to_led_top #(
	parameter int LED_COUNT    = chled_pkg::LED_COUNT_DEF,
	parameter int CORDIC_STEPS = chled_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic signed [15:0]            mag_x,
	input  logic signed [15:0]            mag_y,
	input  logic signed [15:0]            mag_z,
	input  logic signed [15:0]            accel_x,
	input  logic signed [15:0]            accel_y,
	input  logic signed [15:0]            accel_z,
	input  logic [15:0]                   target_bearing,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_index,
	input  logic [7:0]                    cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [$clog2(LED_COUNT)-1:0]  led_index,
	output logic [17:0]                   heading_q8,
	output logic                          heading_valid
);
	localparam int LW = $clog2(LED_COUNT);
	localparam int MW = chled_pkg::MUL_W;
	localparam int PW = 2 * MW;
	localparam int LED_MUL = LED_COUNT * chled_pkg::RECIP_180;
	localparam logic [6:0] LED_MAX = 7'(LED_COUNT - 1);

	chled_pkg::state_t state_q, state_d;

	logic        accept;
	logic        out_free, out_load, cordic_start;
	logic [2:0]  cnt_q;
	logic        hv_q;

	logic [7:0]  decl_q, off_q;
	logic signed [15:0] min_q [3];
	logic signed [15:0] max_q [3];
	logic signed [15:0] mag [3];
	logic signed [15:0] acc [3];

	logic signed [17:0] c_q [3];
	logic signed [15:0] a_q [3];
	logic [15:0]        target_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;
	logic signed [chled_pkg::CROSS_W-1:0] ey_q, ez_q;

	chled_pkg::cordic_res_t cres;

	logic signed [27:0] raw_q, raw_w;
	logic [17:0]        h8;
	logic [21:0]        num_q;
	logic [17:0]        filt_q;
	logic signed [25:0] d0, d1, d2;
	logic [25:0]        dmag;
	logic [7:0]         v_q, v_w;
	logic [6:0]         led_raw;
	logic [LW-1:0]      led_w;

	assign mag[0] = mag_x;   assign mag[1] = mag_y;   assign mag[2] = mag_z;
	assign acc[0] = accel_x; assign acc[1] = accel_y; assign acc[2] = accel_z;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != chled_pkg::ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	// configuration writes, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= chled_pkg::DECL_RST;
			off_q  <= chled_pkg::OFFSET_RST;
		end else if (cfg_valid) begin
			if (cfg_index == chled_pkg::REG_DECLINATION) decl_q <= cfg_data;
			if (cfg_index == chled_pkg::REG_OFFSET)      off_q  <= cfg_data;
		end
	end

	// calibration bounds: reset, open, widen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q[0] <= chled_pkg::MIN_RST_X;
			min_q[1] <= chled_pkg::MIN_RST_Y;
			min_q[2] <= chled_pkg::MIN_RST_Z;
			max_q[0] <= chled_pkg::MAX_RST_X;
			max_q[1] <= chled_pkg::MAX_RST_Y;
			max_q[2] <= chled_pkg::MAX_RST_Z;
		end else if (accept) begin
			for (int k = 0; k < 3; k++) begin
				if (operation == chled_pkg::OP_CAL_BEGIN) begin
					min_q[k] <= 16'sh7fff;
					max_q[k] <= -16'sh8000;
				end else if (operation == chled_pkg::OP_CAL_SAMPLE) begin
					if (mag[k] < min_q[k]) min_q[k] <= mag[k];
					if (mag[k] > max_q[k]) max_q[k] <= mag[k];
				end
			end
		end
	end

	// capture beat: hard-iron correction of the field
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [16:0] s;
				logic signed [16:0] mean;
				s    = 17'(min_q[k]) + 17'(max_q[k]);
				mean = (s + $signed({16'd0, s[16]})) >>> 1;
				c_q[k] <= 18'(mag[k]) - 18'(mean);
				a_q[k] <= acc[k];
			end
			target_q <= target_bearing;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chled_pkg::ST_IDLE:
				if (accept) begin
					state_d = (operation == chled_pkg::OP_HEADING) ?
						chled_pkg::ST_MUL : chled_pkg::ST_OUT;
				end
			chled_pkg::ST_MUL:    if (cnt_q == 3'd5) state_d = chled_pkg::ST_CORDIC;
			chled_pkg::ST_CORDIC: if (cres.done) state_d = chled_pkg::ST_RAW;
			chled_pkg::ST_RAW:    state_d = chled_pkg::ST_FILT;
			chled_pkg::ST_FILT:   state_d = chled_pkg::ST_FMUL;
			chled_pkg::ST_FMUL:   state_d = chled_pkg::ST_FDIV;
			chled_pkg::ST_FDIV:   state_d = chled_pkg::ST_VIEW;
			chled_pkg::ST_VIEW:   state_d = chled_pkg::ST_LMUL;
			chled_pkg::ST_LMUL:   state_d = chled_pkg::ST_OUT;
			chled_pkg::ST_OUT:    if (out_free) state_d = chled_pkg::ST_IDLE;
			default:              state_d = chled_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and strobes
	always_comb begin
		mul_a        = '0;
		mul_b        = '0;
		cordic_start = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			chled_pkg::ST_MUL: begin
				unique case (cnt_q)
					3'd0: begin mul_a = MW'(c_q[2]); mul_b = MW'(a_q[0]); end
					3'd1: begin mul_a = MW'(c_q[0]); mul_b = MW'(a_q[2]); end
					3'd2: begin mul_a = MW'(c_q[0]); mul_b = MW'(a_q[1]); end
					3'd3: begin mul_a = MW'(c_q[1]); mul_b = MW'(a_q[0]); end
					default: cordic_start = 1'b1;
				endcase
			end
			chled_pkg::ST_FMUL: begin
				mul_a = MW'(num_q);
				mul_b = MW'(chled_pkg::RECIP_20);
			end
			chled_pkg::ST_LMUL: begin
				mul_a = MW'(v_q);
				mul_b = MW'(LED_MUL);
			end
			// hold the LED product while the result waits
			chled_pkg::ST_OUT: begin
				mul_a    = MW'(v_q);
				mul_b    = MW'(LED_MUL);
				out_load = out_free;
			end
			default: ;
		endcase
	end

	// state, step count and beat kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chled_pkg::ST_IDLE;
			cnt_q   <= '0;
			hv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
				hv_q  <= (operation == chled_pkg::OP_HEADING);
			end else if (state_q == chled_pkg::ST_MUL) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// accumulate cross product terms in the cycle after the multiplier operands are set
	always_ff @(posedge clk) begin
		if (state_q == chled_pkg::ST_MUL) begin
			unique case (cnt_q)
				3'd1: ey_q <= prod_q[chled_pkg::CROSS_W-1:0];
				3'd2: ey_q <= ey_q - prod_q[chled_pkg::CROSS_W-1:0];
				3'd3: ez_q <= prod_q[chled_pkg::CROSS_W-1:0];
				3'd4: ez_q <= ez_q - prod_q[chled_pkg::CROSS_W-1:0];
				default: ;
			endcase
		end
	end

	chled_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cordic_start && (cnt_q == 3'd5)),
		.ey    (ey_q),
		.ez    (ez_q),
		.res   (cres)
	);

	// clamp angle, add 180 + declination - offset
	always_comb begin
		logic signed [chled_pkg::ANG_W-1:0] z;
		logic [9:0] adj;
		z = cres.angle;
		if (z > chled_pkg::ANG_180)  z = chled_pkg::ANG_180;
		if (z < -chled_pkg::ANG_180) z = -chled_pkg::ANG_180;
		adj   = 10'd180 + 10'(decl_q) - 10'(off_q);
		raw_w = 28'(z) + {{2{adj[9]}}, adj, 16'b0};
	end

	// wrap once, round to 8 fraction bits
	always_comb begin
		logic signed [27:0] r;
		logic [27:0]        rr;
		r  = raw_q;
		if (r < 0) r = r + 28'sd23592960;
		rr = 28'(r) + 28'd128;
		h8 = rr[25:8];
	end

	// bearing error: wrap, clamp to +-90, truncate, shift by 90
	always_comb begin
		d0 = {2'b00, target_q, 8'b0} - 26'(filt_q);
		d1 = d0;
		if (d0 < -26'sd46080)     d1 = d0 + 26'sd92160;
		else if (d0 > 26'sd46080) d1 = d0 - 26'sd92160;
		d2 = d1;
		if (d1 > 26'sd23040)  d2 = 26'sd23040;
		if (d1 < -26'sd23040) d2 = -26'sd23040;
		dmag = d2[25] ? 26'(-d2) : 26'(d2);
		v_w  = d2[25] ? (8'd90 - dmag[15:8]) : (8'd90 + dmag[15:8]);
	end

	// cap LED at the last one
	assign led_raw = prod_q[30:24];
	assign led_w   = (led_raw > LED_MAX) ? LW'(LED_MAX) : LW'(led_raw);

	// heading datapath steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (state_q == chled_pkg::ST_FDIV) begin
			filt_q <= prod_q[45:28];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == chled_pkg::ST_RAW) raw_q <= raw_w;
		if (state_q == chled_pkg::ST_FILT) begin
			num_q <= (22'(filt_q) << 4) + (22'(filt_q) << 1) + 22'(filt_q)
				+ 22'(h8) + 22'd10;
		end
		if (state_q == chled_pkg::ST_VIEW) v_q <= v_w;
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			led_index     <= hv_q ? led_w : '0;
			heading_q8    <= hv_q ? filt_q : '0;
			heading_valid <= hv_q;
		end
	end

endmodule

/* bench/chled_checker.sv */
`timescale 1ns / 1ps
// Checker for compass_heading_to_led_top: watches the item, result and register
// channels, predicts each result and compares it field by field. Uses chled_pkg.
module chled_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [15:0]        target_bearing,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         led_index,
	input  logic [17:0]        heading_q8,
	input  logic               heading_valid,
	output int                 errors,
	output int                 pending
);
	import chled_pkg::*;

	typedef struct {
		logic [2:0]  led;
		logic [17:0] heading;
		logic        hvalid;
	} pointer_t;

	localparam longint DEG = 65536;

	pointer_t    pointer_q[$];
	logic signed [15:0] lo_bound[3];
	logic signed [15:0] hi_bound[3];
	logic [17:0] smooth_heading;
	logic [7:0]  decl_reg;
	logic [7:0]  offset_reg;
	longint      arctan_step[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	assign pending = pointer_q.size();

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// vectoring rotation toward the x axis, angle in degrees with 16 fraction bits
	function automatic longint bearing_angle(input longint ey, input longint ez);
		longint x, y, z, t, dx, dy;
		x = ez * 1048576;
		y = ey * 1048576;
		z = 0;
		if (ey == 0 && ez == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 90 * DEG;
			end else begin
				x = -y; y = t; z = -90 * DEG;
			end
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += arctan_step[i];
			end else begin
				x -= dx; y += dy; z -= arctan_step[i];
			end
		end
		if (z > 180 * DEG) z = 180 * DEG;
		if (z < -180 * DEG) z = -180 * DEG;
		return z;
	endfunction

	// advance calibration and filter state for one beat, return its result
	function automatic pointer_t point_led(input logic [1:0] op,
		input logic signed [15:0] m[3], input logic signed [15:0] a[3],
		input logic [15:0] tgt);
		pointer_t r;
		longint c[3], ey, ez, raw, h8, d, v, led;
		int s;
		r = '{3'd0, 18'd0, 1'b0};
		case (op)
			OP_CAL_BEGIN: begin
				for (int k = 0; k < 3; k++) begin
					lo_bound[k] = 16'sh7fff;
					hi_bound[k] = 16'sh8000;
				end
			end
			OP_CAL_SAMPLE: begin
				for (int k = 0; k < 3; k++) begin
					if (m[k] < lo_bound[k]) lo_bound[k] = m[k];
					if (m[k] > hi_bound[k]) hi_bound[k] = m[k];
				end
			end
			OP_HEADING: begin
				for (int k = 0; k < 3; k++) begin
					s = int'(lo_bound[k]) + int'(hi_bound[k]);
					c[k] = longint'(m[k]) - (s / 2);
				end
				ey = c[2] * a[0] - c[0] * a[2];
				ez = c[0] * a[1] - c[1] * a[0];
				raw = bearing_angle(ey, ez) + 180 * DEG + longint'(decl_reg) * DEG
					- longint'(offset_reg) * DEG;
				if (raw < 0) raw += 360 * DEG;
				h8 = (raw + 128) >>> 8;
				smooth_heading = 18'((19 * longint'(smooth_heading) + h8 + 10) / 20);
				d = longint'(tgt) * 256 - longint'(smooth_heading);
				if (d < -180 * 256) d += 360 * 256;
				if (d > 180 * 256) d -= 360 * 256;
				if (d > 90 * 256) d = 90 * 256;
				if (d < -90 * 256) d = -90 * 256;
				v = (d >= 0) ? (d >>> 8) : -((-d) >>> 8);
				led = ((v + 90) * LED_COUNT_DEF) / 180;
				if (led > LED_COUNT_DEF - 1) led = LED_COUNT_DEF - 1;
				r = '{3'(led), smooth_heading, 1'b1};
			end
			default: ;
		endcase
		return r;
	endfunction

	// predict on accepted beats, compare on delivered beats
	always @(posedge clk or negedge arst_n) begin
		pointer_t exp_r;
		logic signed [15:0] m[3], a[3];
		if (!arst_n) begin
			lo_bound = '{MIN_RST_X, MIN_RST_Y, MIN_RST_Z};
			hi_bound = '{MAX_RST_X, MAX_RST_Y, MAX_RST_Z};
			smooth_heading = '0;
			decl_reg = DECL_RST;
			offset_reg = OFFSET_RST;
			pointer_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DECLINATION) decl_reg = cfg_data;
				else if (cfg_index == REG_OFFSET) offset_reg = cfg_data;
			end
			if (in_valid && !in_stall) begin
				m = '{mag_x, mag_y, mag_z};
				a = '{accel_x, accel_y, accel_z};
				pointer_q.push_back(point_led(operation, m, a, target_bearing));
			end
			if (out_valid && !out_stall) begin
				if (pointer_q.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					exp_r = pointer_q.pop_front();
					if (led_index !== exp_r.led)
						report($sformatf("led_index %0d, expected %0d", led_index, exp_r.led));
					if (heading_q8 !== exp_r.heading)
						report($sformatf("heading_q8 %0d, expected %0d",
							heading_q8, exp_r.heading));
					if (heading_valid !== exp_r.hvalid)
						report($sformatf("heading_valid %0b, expected %0b",
							heading_valid, exp_r.hvalid));
				end
			end
		end
	end
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for compass_heading_to_led_top: drives directed and random
// sensor beats and register writes; chled_checker predicts and compares.
module tb_top;
	import chled_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic [1:0] operation = OP_CAL_BEGIN;
	logic signed [15:0] mag_x = '0, mag_y = '0, mag_z = '0;
	logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic [15:0] target_bearing = '0;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [7:0] cfg_index = '0, cfg_data = '0;
	logic out_valid, out_stall = 1'b0;
	logic [2:0] led_index;
	logic [17:0] heading_q8;
	logic heading_valid;
	int errors, pending;
	bit quiet = 1'b0;
	int n_items = 0, n_heading = 0, stall_left = 0;

	always #10 clk = ~clk;

	compass_heading_to_led_top u_dut (.*);

	chled_checker u_chk (.*);

	// receiver stall in random bursts
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!quiet && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 9);
		out_stall <= (stall_left > 0);
	end

	task automatic send_beat(input logic [1:0] op, input logic [15:0] mx, my, mz,
		input logic [15:0] ax, ay, az, input logic [15:0] tgt);
		bit taken;
		in_valid <= 1'b1;
		operation <= op;
		mag_x <= mx; mag_y <= my; mag_z <= mz;
		accel_x <= ax; accel_y <= ay; accel_z <= az;
		target_bearing <= tgt;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		n_items++;
		if (op == OP_HEADING) n_heading++;
		// drop valid for a random gap
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] sensor_value();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 4000)) - 2000);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	function automatic logic [15:0] bearing_value();
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 359));
	endfunction

	task automatic random_heading();
		send_beat(OP_HEADING, sensor_value(), sensor_value(), sensor_value(),
			sensor_value(), sensor_value(), sensor_value(), bearing_value());
	endtask

	task automatic random_phase(input int count);
		int done_items;
		done_items = 0;
		while (done_items < count) begin
			case ($urandom_range(0, 9))
				0: begin
					// calibration sweep: an opening beat followed by up to eight samples
					send_beat(OP_CAL_BEGIN, sensor_value(), sensor_value(), sensor_value(),
						sensor_value(), sensor_value(), sensor_value(), bearing_value());
					repeat ($urandom_range(0, 8)) begin
						send_beat(OP_CAL_SAMPLE, sensor_value(), sensor_value(),
							sensor_value(), sensor_value(), sensor_value(),
							sensor_value(), bearing_value());
						done_items++;
					end
					done_items++;
				end
				1: begin
					send_beat(OP_CAL_SAMPLE, sensor_value(), sensor_value(), sensor_value(),
						sensor_value(), sensor_value(), sensor_value(), bearing_value());
					done_items++;
				end
				2: begin
					if ($urandom_range(0, 3) == 0)
						send_beat(2'd3, 16'($urandom), 16'($urandom), 16'($urandom),
							16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
					else
						random_heading();
					done_items++;
				end
				default: begin
					random_heading();
					done_items++;
				end
			endcase
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: calibration center gives a zero cross product
		send_beat(OP_HEADING, 16'sd17, 16'sd11, 16'sd58, 16'sd100, -16'sd50, 16'sd9, 16'd0);
		send_beat(OP_HEADING, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'd359);
		send_beat(OP_HEADING, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'hffff);
		send_beat(OP_HEADING, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'd180);
		send_beat(OP_HEADING, 16'sd1017, 16'sd11, 16'sd58, 16'sd0, -16'sd1000, 16'sd0,
			16'd90);
		send_beat(OP_HEADING, 16'sd1017, 16'sd11, 16'sd58, 16'sd0, 16'sd1000, 16'sd0,
			16'd270);
		send_beat(OP_HEADING, 16'sd17, 16'sd11, 16'sd1058, 16'sd1000, 16'sd0, 16'sd0, 16'd45);
		send_beat(OP_HEADING, 16'sd17, 16'sd11, -16'sd942, 16'sd1000, 16'sd0, 16'sd0, 16'd300);
		send_beat(2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		// inverted bounds straight after opening a calibration
		send_beat(OP_CAL_BEGIN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_beat(OP_HEADING, 16'sd300, -16'sd200, 16'sd100, 16'sd50, 16'sd900, -16'sd400,
			16'd10);
		send_beat(OP_CAL_SAMPLE, 16'h8000, 16'h7fff, 16'sd5, 16'd0, 16'd0, 16'd0, 16'd0);
		send_beat(OP_CAL_SAMPLE, 16'h7fff, 16'h8000, -16'sd5, 16'd0, 16'd0, 16'd0, 16'd0);
		send_beat(OP_HEADING, 16'sd300, -16'sd200, 16'sd100, 16'sd50, 16'sd900, -16'sd400,
			16'd200);
		random_phase(200);

		// register settings, extremes first
		drain();
		write_reg(REG_DECLINATION, 8'd0);
		write_reg(REG_OFFSET, 8'd0);
		random_phase(250);
		drain();
		write_reg(REG_DECLINATION, 8'd255);
		write_reg(REG_OFFSET, 8'd255);
		random_phase(250);
		drain();
		write_reg(REG_DECLINATION, 8'd0);
		write_reg(8'd2, 8'd77);
		write_reg(8'hff, 8'd3);
		random_phase(250);
		drain();
		write_reg(REG_DECLINATION, 8'd255);
		write_reg(REG_OFFSET, 8'd0);
		random_phase(250);
		drain();
		write_reg(REG_DECLINATION, 8'($urandom));
		write_reg(REG_OFFSET, 8'($urandom));
		random_phase(200);
		// closing stretch at full rate
		quiet = 1'b1;
		random_phase(300);

		drain();
		$display("%0d sensor beats sent, %0d of them heading samples, over six register settings",
			n_items, n_heading);
		if (errors == 0)
			$display("compass_heading_to_led_top verification clean");
		else
			$display("compass_heading_to_led_top verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", pending);
		$display("compass_heading_to_led_top verification failed");
		$finish;
	end
endmodule
